>>> rtl/modular_inverse_ext_euclid_top_assert.svh
// Assertion macros shared by the modular inverse RTL.
// Each macro checks with clk_i and holds off while rst_ni is low.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared widths and divider handshake types for the modular inverse block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  // Word width of value, modulus and inverse
  localparam int unsigned DataWidth = 16;
  // Counter width for the bit-serial divider (holds DataWidth itself)
  localparam int unsigned CntWidth  = $clog2(DataWidth + 1);
  // Full product width for the coefficient update
  localparam int unsigned ProdWidth = 2 * DataWidth;
  // Modulus after reset
  localparam logic [DataWidth-1:0] ModulusReset = DataWidth'(26);

  // Request into the shared divider
  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quot;
    logic [DataWidth-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/mie_div.sv
// ----------------------------------------------------------------------------
// mie_div
// Bit-serial restoring divider: one quotient bit per cycle, done pulse after
// DataWidth steps. The divisor must be nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modular_inverse_ext_euclid_top_assert.svh"

module mie_div
  import mie_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [CntWidth-1:0]  cnt_q;
  logic [DataWidth-1:0] rem_q;
  logic [DataWidth-1:0] quot_q;
  logic [DataWidth-1:0] dvs_q;

  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   diff;
  logic                 qbit;
  logic [DataWidth-1:0] rem_d;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_shift = {rem_q, quot_q[DataWidth-1]};
    diff      = rem_shift - {1'b0, dvs_q};
    qbit      = ~diff[DataWidth];
    rem_d     = qbit ? diff[DataWidth-1:0] : rem_shift[DataWidth-1:0];
  end

  // Control: busy while stepping, one-cycle done pulse at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(DataWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[DataWidth-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  `MIE_ASSERT_IMP(a_start_when_free, req_i.start, !busy_q, "divider started while busy")
  `MIE_ASSERT_NXT(a_last_step_done, busy_q && !req_i.start && cnt_q == CntWidth'(1),
                  done_q && !busy_q, "divider missed its done pulse")
  `MIE_ASSERT_IMP(a_rem_below_dvs, done_q, rem_q < dvs_q, "remainder not below divisor")

endmodule

`default_nettype wire

>>> rtl/modular_inverse_ext_euclid_top.sv
// Modular inverse by the extended Euclidean algorithm.
// Input channel s_axis: one item is a 16-bit value. Output channel m_axis:
// one item per input, the inverse modulo the configured modulus in bits
// 15:0 and an exists flag in bit 16. When no inverse exists (value zero
// after reduction, gcd not one, or a modulus below two) exists is 0 and the
// inverse is 0. The user must write the modulus through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block itself does not
// enforce this. Reset sets it to 26. One item is handled at a time. A
// single bit-serial divider does every division: the value is first
// reduced modulo the modulus, then each Euclid step runs one division
// with its capture and one coefficient update in StUpd. The input is
// ready again in the same cycle as the result becomes valid.
// s_axis_tready_o is high only while the sequencer is idle. The finished
// result sits in an output register, so a new item is taken while it still
// waits; if the receiver stalls, the next result waits in the sequencer
// until the output register frees up. Reset drops any item in progress and
// any undelivered result.
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top
// Sequencer, Bezout coefficient tracking and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modular_inverse_ext_euclid_top_assert.svh"

module modular_inverse_ext_euclid_top
  import mie_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration: modulus
  input  wire logic                 cfg_we_i,
  input  wire logic [DataWidth-1:0] cfg_wdata_i,
  // Input items
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [15:0]          s_axis_tdata_i,  // [15:0] value
  // Result items
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [23:0]               m_axis_tdata_o   // [15:0] inverse, [16] exists
);

  localparam int unsigned StateWidth = 3;
  localparam logic [StateWidth-1:0] StIdle = 3'd0;
  localparam logic [StateWidth-1:0] StRed  = 3'd1;
  localparam logic [StateWidth-1:0] StDiv  = 3'd2;
  localparam logic [StateWidth-1:0] StUpd  = 3'd3;
  localparam logic [StateWidth-1:0] StRes  = 3'd4;
  localparam logic [StateWidth-1:0] StOut  = 3'd5;

  logic [StateWidth-1:0] state_q;
  logic [DataWidth-1:0]  modulus_q;
  logic [DataWidth-1:0]  m_q;
  logic [DataWidth-1:0]  rp_q, rc_q, tp_q, tc_q, q_q, r_q;
  logic                  negp_q, negc_q;
  logic [DataWidth-1:0]  res_inv_q;
  logic                  res_ok_q;
  logic                  out_valid_q;
  logic [DataWidth-1:0]  out_inv_q;
  logic                  out_ok_q;

  logic                  in_fire;
  logic                  mod_ok;
  logic [ProdWidth-1:0]  prod;
  logic [DataWidth-1:0]  tn;
  logic                  out_free;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign mod_ok   = modulus_q >= DataWidth'(2);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Next Bezout coefficient magnitude: tp + q * tc (stays within the modulus)
  always_comb begin
    prod = ProdWidth'(q_q) * ProdWidth'(tc_q);
    tn   = tp_q + prod[DataWidth-1:0];
  end

  // Divider requests: reduce the value, then one division per Euclid step
  always_comb begin
    div_req = '0;
    unique case (state_q)
      StIdle: begin
        div_req.start    = in_fire && mod_ok;
        div_req.dividend = s_axis_tdata_i[DataWidth-1:0];
        div_req.divisor  = modulus_q;
      end
      StRed: begin
        div_req.start    = div_rsp.done && (div_rsp.rem != '0);
        div_req.dividend = m_q;
        div_req.divisor  = div_rsp.rem;
      end
      StUpd: begin
        div_req.start    = r_q != '0;
        div_req.dividend = rc_q;
        div_req.divisor  = r_q;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  mie_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            state_q <= mod_ok ? StRed : StOut;
          end
        end
        StRed: begin
          if (div_rsp.done) begin
            state_q <= (div_rsp.rem == '0) ? StOut : StDiv;
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            state_q <= StUpd;
          end
        end
        StUpd: begin
          state_q <= (r_q == '0) ? StRes : StDiv;
        end
        StRes: begin
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Euclid datapath and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          m_q       <= modulus_q;
          res_ok_q  <= 1'b0;
          res_inv_q <= '0;
        end
      end
      StRed: begin
        if (div_rsp.done) begin
          rp_q   <= m_q;
          rc_q   <= div_rsp.rem;
          tp_q   <= '0;
          tc_q   <= DataWidth'(1);
          negp_q <= 1'b0;
          negc_q <= 1'b0;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          q_q <= div_rsp.quot;
          r_q <= div_rsp.rem;
        end
      end
      StUpd: begin
        rp_q   <= rc_q;
        rc_q   <= r_q;
        tp_q   <= tc_q;
        tc_q   <= tn;
        negp_q <= negc_q;
        negc_q <= !negc_q;
      end
      StRes: begin
        // Inverse exists only when the gcd ended at one; fold a negative back
        res_ok_q <= rp_q == DataWidth'(1);
        if (rp_q != DataWidth'(1)) begin
          res_inv_q <= '0;
        end else if (negp_q && tp_q != '0) begin
          res_inv_q <= m_q - tp_q;
        end else begin
          res_inv_q <= tp_q;
        end
      end
      StOut: begin
        if (out_free) begin
          out_inv_q <= res_inv_q;
          out_ok_q  <= res_ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready_o = state_q == StIdle;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_ok_q, out_inv_q};

  `MIE_ASSERT_IMP(a_done_when_waiting, div_rsp.done, state_q == StRed || state_q == StDiv,
                  "divider result arrived outside a wait state")
  `MIE_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_q != StIdle,
                  "sequencer stayed idle after taking an item")
  `MIE_ASSERT_IMP(a_inverse_in_range, state_q == StOut && res_ok_q,
                  res_inv_q < m_q && m_q >= DataWidth'(2), "inverse not below modulus")
  `MIE_ASSERT_IMP(a_no_inverse_zero, state_q == StOut && !res_ok_q, res_inv_q == '0,
                  "nonzero inverse reported without an inverse")

endmodule

`default_nettype wire
